FILE: design/guide_table_nearest_match_unit_defines.svh
// Assertion macros for the guide table block.
`ifndef GUIDE_TABLE_NEAREST_MATCH_UNIT_DEFINES_SVH
`define GUIDE_TABLE_NEAREST_MATCH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define GTNM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GTNM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GTNM_ASSERT(lbl, prop, msg)
`define GTNM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: design/gtnm_pkg.sv
package gtnm_pkg;

  localparam int COORD_W = 32;
  localparam int DIST_W  = COORD_W + 1;
  localparam int TOL_W   = 31;
  localparam int AXIS_W  = 2;
  localparam int FUNC_W  = 3;

  localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_NEAREST = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd4;

  localparam logic [AXIS_W-1:0] AXIS_ANGLED = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RM_HEAD,
    ST_RM_SHIFT,
    ST_NEAR,
    ST_NEAR_FLUSH,
    ST_NEAR_FIN,
    ST_READ
  } st_e;

  typedef struct packed {
    logic [AXIS_W-1:0]  axis;
    logic [COORD_W-1:0] coord;
    logic [COORD_W-1:0] angle;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               ray;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

endpackage

FILE: design/gtnm_scan.sv
module gtnm_scan #(
  parameter int IDX_W = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gtnm_pkg::scan_ctl_t        ctl_i,
  input  logic [1:0]                 query_axis_i,
  input  logic [31:0]                query_coord_i,
  input  logic [30:0]                tol_i,
  input  logic [1:0]                 entry_axis_i,
  input  logic [31:0]                entry_coord_i,
  input  logic [IDX_W-1:0]           entry_idx_i,
  output logic                       found_o,
  output logic [IDX_W-1:0]           best_idx_o
);
  import gtnm_pkg::*;

  logic signed [DIST_W-1:0] s_ext, c_ext, diff_a, diff_b;
  logic [DIST_W-1:0]        abs_d;

  logic                     s1_valid_q;
  logic                     s1_match_q;
  logic [DIST_W-1:0]        s1_dist_q;
  logic [IDX_W-1:0]         s1_idx_q;

  logic                     found_q;
  logic [DIST_W-1:0]        best_d_q;
  logic [IDX_W-1:0]         best_idx_q;
  logic                     take;

  // stage 1: exact distance, one bit wider than the coordinate
  always_comb begin
    s_ext  = {entry_coord_i[COORD_W-1], entry_coord_i};
    c_ext  = {query_coord_i[COORD_W-1], query_coord_i};
    diff_a = s_ext - c_ext;
    diff_b = c_ext - s_ext;
    abs_d  = diff_a[DIST_W-1] ? diff_b : diff_a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= ctl_i.step & ~ctl_i.clear;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_match_q <= (entry_axis_i == query_axis_i);
    s1_dist_q  <= abs_d;
    s1_idx_q   <= entry_idx_i;
  end

  // stage 2: first in-range entry wins, later only if strictly nearer
  assign take = s1_valid_q & s1_match_q &
                (found_q ? (s1_dist_q < best_d_q) : (s1_dist_q <= best_d_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      best_d_q <= {{(DIST_W-TOL_W){1'b0}}, tol_i};
    end else if (take) begin
      best_d_q   <= s1_dist_q;
      best_idx_q <= s1_idx_q;
    end
  end

  assign found_o    = found_q;
  assign best_idx_o = best_idx_q;

endmodule

FILE: design/guide_table_nearest_match_unit.sv
// Add, clear, unused codes, failing remove/read and nearest on an empty table answer from idle;
// read, a valid remove and nearest on a filled table pass through their own states first.
// One item at a time; busy stays high until the result is ready. The single table memory
// port pair sets the rate: compaction and the nearest scan walk one entry per cycle.
// Reset clears count, angled count and control; table contents stay undefined, no sweep.
// The done_o strobe lasts one cycle and cannot be stalled by the receiver.
`include "guide_table_nearest_match_unit_defines.svh"

module guide_table_nearest_match_unit #(
  parameter int ENTRIES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  output logic                              done_o,
  input  logic [2:0]                        func_i,
  input  logic [1:0]                        axis_i,
  input  logic signed [31:0]                coordinate_i,
  input  logic signed [31:0]                angle_i,
  input  logic signed [31:0]                point_x_i,
  input  logic signed [31:0]                point_y_i,
  input  logic                              ray_flag_i,
  input  logic [$clog2(ENTRIES+1)-1:0]      entry_index_i,
  input  logic [30:0]                       tolerance_i,
  output logic [$clog2(ENTRIES+1)-1:0]      result_index_o,
  output logic                              ok_o,
  output logic [1:0]                        out_axis_o,
  output logic signed [31:0]                out_coordinate_o,
  output logic signed [31:0]                out_angle_o,
  output logic signed [31:0]                out_x_o,
  output logic signed [31:0]                out_y_o,
  output logic                              out_ray_o,
  output logic [$clog2(ENTRIES+1)-1:0]      entry_count_o,
  output logic                              has_angled_o
);
  import gtnm_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

  st_e state_q, state_d;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] ang_q, ang_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [CNT_W:0]   ptr_p1, ptr_p2;
  logic             accept;

  // table memory: one write and one registered read per cycle
  entry_t           mem [ENTRIES];
  entry_t           rd_data_q;
  entry_t           wr_data;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             wr_en;

  // query held for the nearest scan
  logic [1:0]       qaxis_q;
  logic [31:0]      qcoord_q;

  // result registers
  logic [CNT_W-1:0] res_q, res_d;
  logic             ok_q, ok_d;
  entry_t           oent_q, oent_d;
  logic             done_q, done_d;

  scan_ctl_t        scan_ctl;
  logic             scan_found;
  logic [CNT_W-1:0] scan_idx;

  assign accept = start & (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);
  assign ptr_p1 = {1'b0, ptr_q} + (CNT_W+1)'(1);
  assign ptr_p2 = {1'b0, ptr_q} + (CNT_W+1)'(2);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (func_i)
            FUNC_REMOVE:  if (entry_index_i < cnt_q) state_d = ST_RM_HEAD;
            FUNC_NEAREST: if (cnt_q != '0) state_d = ST_NEAR;
            FUNC_READ:    if (entry_index_i < cnt_q) state_d = ST_READ;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_RM_HEAD:    state_d = (ptr_p1 < {1'b0, cnt_q}) ? ST_RM_SHIFT : ST_IDLE;
      ST_RM_SHIFT:   state_d = (ptr_p2 < {1'b0, cnt_q}) ? ST_RM_SHIFT : ST_IDLE;
      ST_NEAR:       state_d = (ptr_p1 < {1'b0, cnt_q}) ? ST_NEAR : ST_NEAR_FLUSH;
      ST_NEAR_FLUSH: state_d = ST_NEAR_FIN;
      ST_NEAR_FIN:   state_d = ST_IDLE;
      ST_READ:       state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_d    = cnt_q;
    ang_d    = ang_q;
    ptr_d    = ptr_q;
    res_d    = res_q;
    ok_d     = ok_q;
    oent_d   = oent_q;
    done_d   = 1'b0;
    rd_addr  = ptr_q[AW-1:0];
    wr_addr  = ptr_q[AW-1:0];
    wr_data  = rd_data_q;
    wr_en    = 1'b0;
    scan_ctl = '0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (func_i)
            FUNC_ADD: begin
              // append every field as given
              oent_d = '0;
              res_d  = cnt_q;
              done_d = 1'b1;
              ok_d   = 1'b0;
              if (cnt_q < FULL) begin
                wr_en   = 1'b1;
                wr_addr = cnt_q[AW-1:0];
                wr_data = '{axis:  axis_i,
                            coord: coordinate_i,
                            angle: angle_i,
                            x:     point_x_i,
                            y:     point_y_i,
                            ray:   ray_flag_i};
                cnt_d   = cnt_q + CNT_W'(1);
                if (axis_i == AXIS_ANGLED) ang_d = ang_q + CNT_W'(1);
                ok_d    = 1'b1;
              end
            end
            FUNC_REMOVE, FUNC_READ: begin
              rd_addr = entry_index_i[AW-1:0];
              ptr_d   = entry_index_i;
              if (entry_index_i >= cnt_q) begin
                res_d  = '0;
                ok_d   = 1'b0;
                oent_d = '0;
                done_d = 1'b1;
              end
            end
            FUNC_NEAREST: begin
              scan_ctl.clear = 1'b1;
              rd_addr        = '0;
              ptr_d          = '0;
              if (cnt_q == '0) begin
                res_d  = cnt_q;
                ok_d   = 1'b0;
                oent_d = '0;
                done_d = 1'b1;
              end
            end
            FUNC_CLEAR: begin
              cnt_d  = '0;
              ang_d  = '0;
              res_d  = '0;
              ok_d   = 1'b1;
              oent_d = '0;
              done_d = 1'b1;
            end
            default: begin
              res_d  = '0;
              ok_d   = 1'b0;
              oent_d = '0;
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_RM_HEAD: begin
        // the removed entry is on the read port now
        if (rd_data_q.axis == AXIS_ANGLED) ang_d = ang_q - CNT_W'(1);
        rd_addr = ptr_p1[AW-1:0];
        if (ptr_p1 >= {1'b0, cnt_q}) begin
          cnt_d  = cnt_q - CNT_W'(1);
          res_d  = '0;
          ok_d   = 1'b1;
          oent_d = '0;
          done_d = 1'b1;
        end
      end
      ST_RM_SHIFT: begin
        // move entry ptr+1 down to ptr, fetch the next one
        wr_en   = 1'b1;
        wr_addr = ptr_q[AW-1:0];
        wr_data = rd_data_q;
        ptr_d   = ptr_p1[CNT_W-1:0];
        rd_addr = ptr_p2[AW-1:0];
        if (ptr_p2 >= {1'b0, cnt_q}) begin
          cnt_d  = cnt_q - CNT_W'(1);
          res_d  = '0;
          ok_d   = 1'b1;
          oent_d = '0;
          done_d = 1'b1;
        end
      end
      ST_NEAR: begin
        scan_ctl.step = 1'b1;
        ptr_d         = ptr_p1[CNT_W-1:0];
        rd_addr       = ptr_p1[AW-1:0];
      end
      ST_NEAR_FLUSH: begin
        // drain the two scan stages
      end
      ST_NEAR_FIN: begin
        res_d  = scan_found ? scan_idx : cnt_q;
        ok_d   = scan_found;
        oent_d = '0;
        done_d = 1'b1;
      end
      ST_READ: begin
        res_d  = '0;
        ok_d   = 1'b1;
        oent_d = rd_data_q;
        done_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ang_q   <= '0;
      ptr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ang_q   <= ang_d;
      ptr_q   <= ptr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    ok_q   <= ok_d;
    oent_q <= oent_d;
    if (accept) begin
      qaxis_q  <= axis_i;
      qcoord_q <= coordinate_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_q <= mem[rd_addr];
  end

  gtnm_scan #(
    .IDX_W (CNT_W)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (scan_ctl),
    .query_axis_i  (qaxis_q),
    .query_coord_i (qcoord_q),
    .tol_i         (tolerance_i),
    .entry_axis_i  (rd_data_q.axis),
    .entry_coord_i (rd_data_q.coord),
    .entry_idx_i   (ptr_q),
    .found_o       (scan_found),
    .best_idx_o    (scan_idx)
  );

  // results: count and angled flag track the table directly
  assign done_o           = done_q;
  assign result_index_o   = res_q;
  assign ok_o             = ok_q;
  assign out_axis_o       = oent_q.axis;
  assign out_coordinate_o = oent_q.coord;
  assign out_angle_o      = oent_q.angle;
  assign out_x_o          = oent_q.x;
  assign out_y_o          = oent_q.y;
  assign out_ray_o        = oent_q.ray;
  assign entry_count_o    = cnt_q;
  assign has_angled_o     = (ang_q != '0);

  `GTNM_ASSERT(a_done_when_idle, done_o |-> !busy, "result strobe while busy")
  `GTNM_ASSERT(a_count_bound, cnt_q <= FULL, "entry count above table size")
  `GTNM_ASSERT(a_angled_bound, ang_q <= cnt_q, "angled count above entry count")
  `GTNM_ASSERT_NEXT(a_add_quick, accept && func_i == FUNC_ADD, done_o, "add was slow")
  `GTNM_ASSERT_NEXT(a_clear_quick, accept && func_i == FUNC_CLEAR, done_o, "clear was slow")

endmodule
